/* src/fwcfg_pkg.sv */
// Package for the firmware configuration item server: default values, operation and status codes.
// It also holds the byte tables of the fixed items.
// It has no dependencies.
package fwcfg_pkg;

  localparam int unsigned DefMaxFiles  = 16;
  localparam int unsigned DefPathLen   = 56;
  localparam int unsigned DefFileBytes = 4096;

  localparam logic [15:0] RstSignatureKey = 16'd0;
  localparam logic [15:0] RstIdKey        = 16'd1;
  localparam logic [15:0] RstDirectoryKey = 16'd25;
  localparam logic [15:0] RstFirstFileKey = 16'd32;

  typedef enum logic [2:0] {
    OP_SELECT = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_SKIP   = 3'd3,
    OP_ADD    = 3'd4,
    OP_NAME   = 3'd5,
    OP_DATA   = 3'd6,
    OP_RESET  = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_NAME_LONG = 3'd2,
    ST_TOO_BIG   = 3'd3,
    ST_NOT_WR    = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    REG_SIGNATURE = 2'd0,
    REG_ID        = 2'd1,
    REG_DIRECTORY = 2'd2,
    REG_FIRST     = 2'd3
  } reg_e;

  // Signature item "QEMU".
  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h51;
      2'd1:    b = 8'h45;
      2'd2:    b = 8'h4D;
      default: b = 8'h55;
    endcase
    return b;
  endfunction

  // Feature id item 03 00 00 00.
  function automatic logic [7:0] id_byte(input logic [1:0] idx);
    return (idx == 2'd0) ? 8'h03 : 8'h00;
  endfunction

  // Byte p of a big-endian 32-bit word.
  function automatic logic [7:0] be32_byte(input logic [31:0] v, input logic [1:0] p);
    logic [7:0] b;
    case (p)
      2'd0:    b = v[31:24];
      2'd1:    b = v[23:16];
      2'd2:    b = v[15:8];
      default: b = v[7:0];
    endcase
    return b;
  endfunction

endpackage

/* src/firmware_config_item_server_unit.sv */
// Top level of the firmware configuration item server: control sequencer and the three stores.
// The stores are the file table, the name characters and the file data.
// It depends on fwcfg_pkg.
//
// The server takes one beat at a time and returns one result beat for each. A beat is taken
// when the sequencer is idle. Its result is loaded into the output register in the result
// step, after which the sequencer is idle again and can take a new beat. The result stays
// in the output register until it is taken, and the next input beat may be accepted
// meanwhile. If that next result is formed while the previous one is still waiting, the
// sequencer holds in its result step and takes no input until the receiver takes the old
// result. The steps run in this order. The accepting edge captures the beat. The
// calculation step computes the key class and the directory entry estimate by reciprocal
// multiplication. The correction step turns that estimate into an entry index and a byte
// position. The read step does the synchronous read of the file table, name and data
// memories. The result step forms the result and writes back any change. A directory
// offset is split into entry and byte by multiplying with a constant reciprocal, so no
// divider is present. File keys are found by subtracting the first file key from the
// selected key, not by searching the table. The stores power up undefined; only file table
// entries that have been written are ever returned.
module firmware_config_item_server_unit
  import fwcfg_pkg::*;
#(
  parameter int unsigned MAX_FILES  = DefMaxFiles,
  parameter int unsigned PATH_LEN   = DefPathLen,
  parameter int unsigned FILE_BYTES = DefFileBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  operation_i,
  input  logic [15:0] item_key_i,
  input  logic [3:0]  file_slot_i,
  input  logic [11:0] position_i,
  input  logic [7:0]  byte_value_i,
  input  logic [31:0] amount_i,
  input  logic        writable_i,
  input  logic [5:0]  name_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  read_data_o,
  output logic [15:0] assigned_key_o,
  output logic [2:0]  status_o
);

  localparam int unsigned EntryBytes = 8 + PATH_LEN;
  localparam int unsigned DirBytes   = MAX_FILES * EntryBytes;
  localparam int unsigned RW         = $clog2(DirBytes);
  localparam int unsigned Shift      = RW + 8;
  localparam int unsigned Recip      = (2 ** Shift) / EntryBytes;
  localparam int unsigned MW         = (MAX_FILES > 1) ? $clog2(MAX_FILES) : 1;
  localparam int unsigned TW         = $clog2(MAX_FILES + 1);
  localparam int unsigned PW         = $clog2(EntryBytes);
  localparam int unsigned SZW        = $clog2(FILE_BYTES + 1);
  localparam int unsigned NAW        = $clog2(MAX_FILES * PATH_LEN);
  localparam int unsigned DAW        = $clog2(MAX_FILES * FILE_BYTES);
  localparam int unsigned MetaW      = 1 + 6 + SZW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_CALC = 3'd1;
  localparam logic [2:0] S_FIX  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  typedef struct packed {
    logic is_sig;
    logic is_id;
    logic is_dir;
    logic is_file;
  } key_class_t;

  // Memories.
  logic [MetaW-1:0] meta_mem [MAX_FILES];
  logic [7:0]       name_mem [MAX_FILES * PATH_LEN];
  logic [7:0]       data_mem [MAX_FILES * FILE_BYTES];

  logic [2:0]  state_q, state_d;
  logic [15:0] sig_key_q, id_key_q, dir_key_q, first_key_q;
  logic [15:0] sel_q;
  logic [31:0] off_q;
  logic [TW-1:0] total_q;

  // Captured beat.
  logic [2:0]  op_q;
  logic [15:0] key_q;
  logic [3:0]  slot_q;
  logic [11:0] pos_q;
  logic [7:0]  bval_q;
  logic [31:0] amount_q;
  logic        wr_q;
  logic [5:0]  nlen_q;

  // Derived per beat.
  key_class_t  kc_q;
  logic [MW-1:0]  fslot_q;
  logic           dir_hit_q;
  logic [RW-1:0]  r_q;
  logic [MW-1:0]  q0_q;
  logic [MW-1:0]  idx_q;
  logic [PW-1:0]  p_q;
  logic [DAW-1:0] daddr_q;

  logic [MetaW-1:0] meta_rd_q;
  logic [7:0]       name_rd_q;
  logic [7:0]       data_rd_q;

  logic        out_valid_q;
  logic [7:0]  rd_q;
  logic [15:0] akey_q;
  logic [2:0]  st_q;

  logic accept;
  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == S_IDLE);

  // Combinational helpers for the calculation step.
  logic [15:0]       kdiff;
  logic [31:0]       rlong;
  logic [RW+Shift:0] prod;
  always_comb begin
    kdiff = sel_q - first_key_q;
    rlong = off_q - 32'd4;
    prod  = (RW + Shift + 1)'(rlong[RW-1:0]) * (RW + Shift + 1)'(Recip);
  end

  // Correction of the reciprocal estimate.
  logic [RW:0] rem0;
  logic [RW:0] rem1;
  logic        fix_up;
  always_comb begin
    rem0   = (RW + 1)'(r_q) - (RW + 1)'(q0_q) * (RW + 1)'(EntryBytes);
    fix_up = (rem0 >= (RW + 1)'(EntryBytes));
    rem1   = fix_up ? rem0 - (RW + 1)'(EntryBytes) : rem0;
  end

  // Read addresses for the memory access step.
  logic [MW-1:0]  meta_ra;
  logic [NAW-1:0] name_ra;
  always_comb begin
    meta_ra = dir_hit_q ? idx_q : fslot_q;
    name_ra = NAW'(NAW'(idx_q) * NAW'(PATH_LEN) + NAW'(p_q) - NAW'(8));
  end

  // Result forming.
  logic [SZW-1:0] msize;
  logic [5:0]     mnlen;
  logic           mwr;
  logic [15:0]    entry_key;
  logic [7:0]     rd_d;
  logic [15:0]    akey_d;
  logic [2:0]     st_d;
  logic           off_in_file;
  logic           wr_found;
  logic           data_we, name_we, meta_we;
  logic [DAW-1:0] data_wa;
  logic [NAW-1:0] name_wa;
  logic [15:0]    sel_d;
  logic [31:0]    off_d;
  logic [TW-1:0]  total_d;
  always_comb begin
    {mwr, mnlen, msize} = meta_rd_q;
    entry_key   = first_key_q + 16'(idx_q);
    off_in_file = (off_q < 32'(msize)) && (off_q < 32'(FILE_BYTES));
    wr_found    = kc_q.is_file && mwr;
    rd_d    = 8'd0;
    akey_d  = 16'd0;
    st_d    = ST_OK;
    data_we = 1'b0;
    name_we = 1'b0;
    meta_we = 1'b0;
    data_wa = daddr_q;
    name_wa = NAW'(NAW'(slot_q) * NAW'(PATH_LEN) + NAW'(pos_q));
    sel_d   = sel_q;
    off_d   = off_q;
    total_d = total_q;
    case (op_q)
      OP_SELECT: begin
        sel_d = key_q;
        off_d = 32'd0;
      end
      OP_READ: begin
        off_d = off_q + 32'd1;
        if (kc_q.is_sig) begin
          rd_d = (off_q < 32'd4) ? sig_byte(off_q[1:0]) : 8'd0;
        end else if (kc_q.is_id) begin
          rd_d = (off_q < 32'd4) ? id_byte(off_q[1:0]) : 8'd0;
        end else if (kc_q.is_dir) begin
          if (off_q < 32'd4) begin
            rd_d = be32_byte(32'(total_q), off_q[1:0]);
          end else if (!dir_hit_q || (32'(idx_q) >= 32'(total_q))) begin
            rd_d = 8'd0;
          end else if (p_q < PW'(4)) begin
            rd_d = be32_byte(32'(msize), p_q[1:0]);
          end else if (p_q == PW'(4)) begin
            rd_d = entry_key[15:8];
          end else if (p_q == PW'(5)) begin
            rd_d = entry_key[7:0];
          end else if (p_q < PW'(8)) begin
            rd_d = 8'd0;
          end else begin
            rd_d = (32'(p_q) - 32'd8 < 32'(mnlen)) ? name_rd_q : 8'd0;
          end
        end else if (kc_q.is_file) begin
          rd_d = off_in_file ? data_rd_q : 8'd0;
        end
      end
      OP_WRITE: begin
        if (!wr_found) begin
          st_d = ST_NOT_WR;
        end else begin
          data_we = off_in_file;
          off_d   = off_q + 32'd1;
        end
      end
      OP_SKIP: begin
        off_d = off_q + amount_q;
      end
      OP_ADD: begin
        if (32'(total_q) >= 32'(MAX_FILES)) begin
          st_d = ST_FULL;
        end else if (32'(nlen_q) >= 32'(PATH_LEN)) begin
          st_d = ST_NAME_LONG;
        end else if (amount_q > 32'(FILE_BYTES)) begin
          st_d = ST_TOO_BIG;
        end else begin
          meta_we = 1'b1;
          akey_d  = first_key_q + 16'(total_q);
          total_d = total_q + TW'(1);
        end
      end
      OP_NAME: begin
        name_we = (32'(slot_q) < 32'(MAX_FILES)) && (32'(pos_q) < 32'(PATH_LEN));
      end
      OP_DATA: begin
        data_we = (32'(slot_q) < 32'(MAX_FILES)) && (32'(pos_q) < 32'(FILE_BYTES));
      end
      default: begin
        sel_d   = 16'd0;
        off_d   = 32'd0;
        total_d = '0;
      end
    endcase
  end

  logic resp_go;
  assign resp_go = (state_q == S_RESP) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (accept) state_d = S_CALC;
      S_CALC:  state_d = S_FIX;
      S_FIX:   state_d = S_READ;
      S_READ:  state_d = S_RESP;
      S_RESP:  if (resp_go) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sig_key_q   <= RstSignatureKey;
      id_key_q    <= RstIdKey;
      dir_key_q   <= RstDirectoryKey;
      first_key_q <= RstFirstFileKey;
      sel_q       <= 16'd0;
      off_q       <= 32'd0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_SIGNATURE: sig_key_q   <= cfg_data_i;
          REG_ID:        id_key_q    <= cfg_data_i;
          REG_DIRECTORY: dir_key_q   <= cfg_data_i;
          default:       first_key_q <= cfg_data_i;
        endcase
      end
      if (resp_go) begin
        sel_q       <= sel_d;
        off_q       <= off_d;
        total_q     <= total_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q     <= operation_i;
      key_q    <= item_key_i;
      slot_q   <= file_slot_i;
      pos_q    <= position_i;
      bval_q   <= byte_value_i;
      amount_q <= amount_i;
      wr_q     <= writable_i;
      nlen_q   <= name_length_i;
    end
    if (state_q == S_CALC) begin
      kc_q.is_sig  <= (sel_q == sig_key_q);
      kc_q.is_id   <= (sel_q == id_key_q);
      kc_q.is_dir  <= (sel_q == dir_key_q);
      kc_q.is_file <= (kdiff < 16'(total_q));
      fslot_q      <= kdiff[MW-1:0];
      dir_hit_q    <= (op_q == OP_READ) && (sel_q != sig_key_q) && (sel_q != id_key_q) &&
                      (sel_q == dir_key_q) && (off_q >= 32'd4) &&
                      (rlong < 32'(DirBytes));
      r_q          <= rlong[RW-1:0];
      q0_q         <= MW'(prod >> Shift);
      if ((op_q == OP_READ) || (op_q == OP_WRITE)) begin
        daddr_q <= DAW'(DAW'(kdiff[MW-1:0]) * DAW'(FILE_BYTES) + DAW'(off_q));
      end else begin
        daddr_q <= DAW'(DAW'(slot_q) * DAW'(FILE_BYTES) + DAW'(pos_q));
      end
    end
    if (state_q == S_FIX) begin
      idx_q <= fix_up ? q0_q + MW'(1) : q0_q;
      p_q   <= PW'(rem1);
    end
    if (resp_go) begin
      rd_q   <= rd_d;
      akey_q <= akey_d;
      st_q   <= st_d;
    end
  end

  // Synchronous memories: one read in the read step, write-back in the result step.
  always_ff @(posedge clk_i) begin
    if (state_q == S_READ) begin
      meta_rd_q <= meta_mem[meta_ra];
      name_rd_q <= name_mem[name_ra];
      data_rd_q <= data_mem[daddr_q];
    end
    if (resp_go && meta_we) begin
      meta_mem[total_q[MW-1:0]] <= {wr_q, nlen_q, SZW'(amount_q)};
    end
    if (resp_go && name_we) begin
      name_mem[name_wa] <= bval_q;
    end
    if (resp_go && data_we) begin
      data_mem[data_wa] <= bval_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = rd_q;
  assign assigned_key_o = akey_q;
  assign status_o       = st_q;

  // The file count never exceeds the table.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= 32'(MAX_FILES))
    else $error("file count beyond table size");

  // The file count changes only at the end of a beat.
  a_total_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q != $past(total_q)) |-> ($past(state_q) == S_RESP))
    else $error("file count changed outside result step");

  // A new result appears only from the result step.
  a_out_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_RESP))
    else $error("result raised outside result step");

  // An accepted beat always starts the calculation step.
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_CALC))
    else $error("accepted beat not processed");

endmodule
